// ===== design/rpfs_pkg.sv =====
`default_nettype none

package rpfs_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int ANGLE_WIDTH = 32;

    localparam int DELTA_W   = COORD_WIDTH + 1;
    localparam int TRIG_W    = 32;
    localparam int TRIG_FRAC = 30;
    localparam int MAG_W     = TRIG_FRAC + 1;
    localparam int PROD_W    = TRIG_W + DELTA_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int SHIFT_W   = SUM_W - TRIG_FRAC;
    localparam int RES_W     = SHIFT_W + 1;

    localparam int REFINE_W = 28;
    localparam logic [REFINE_W-1:0] REFINE_Q30 = 28'd241591910;

    localparam int TURN_W = ANGLE_WIDTH + 1;
    localparam logic [TURN_W:0] TURN_OFFSET = 34'd2170552320;
    localparam int XL_W = 19;
    localparam int XH_W = TURN_W - XL_W;
    localparam int Q45_PROD_W = 28;
    localparam logic [XH_W-1:0] MOD45_RECIP = 14'd11651;
    localparam int Q45_W = 8;
    localparam logic [XH_W-1:0] SECTOR_DIV = 14'd45;
    localparam int MH_W = 6;

    localparam int Y_W = 32;
    localparam int Y_SHIFT = Y_W - 1 - XL_W;
    localparam logic [Y_W-1:0] UQ_STEP_REM = 32'd38;
    localparam logic [Y_W-1:0] ROUND_BIAS = 32'd22;
    localparam int BASE_W = 31;
    localparam logic [BASE_W-1:0] UQ_STEP = 31'd47721858;
    localparam int P5_W = 2 * Y_W;
    localparam logic [Y_W-1:0] DIV45_RECIP = 32'd3054198967;
    localparam int DIV45_SHIFT = 37;
    localparam int QY_W = P5_W - DIV45_SHIFT;

    localparam logic [Y_W-1:0] HALF_TURN    = 32'h4000_0000;
    localparam logic [Y_W-1:0] FULL_TURN    = 32'h8000_0000;
    localparam logic [Y_W-1:0] QUARTER_TURN = 32'h2000_0000;

    localparam int NSTAGE    = 16;
    localparam int CRD_DEPTH = 15;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] pivot_x;
        logic signed [COORD_WIDTH-1:0] pivot_y;
        logic signed [ANGLE_WIDTH-1:0] angle_degrees;
    } in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_x;
        logic signed [COORD_WIDTH-1:0] rotated_y;
    } out_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0]     dx;
        logic signed [DELTA_W-1:0]     dy;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
    } crd_t;

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [RES_W-1:0] v
    );
        logic [RES_W-COORD_WIDTH:0] top;
        top = v[RES_W-1:COORD_WIDTH-1];
        if (top == '0 || top == '1)
        begin
            return v[COORD_WIDTH-1:0];
        end
        else if (v[RES_W-1])
        begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/rpfs_sine.sv =====
`default_nettype none

module rpfs_sine (
    input  logic                               clk,
    input  logic                               en,
    input  logic [rpfs_pkg::MAG_W-1:0]         mag,
    input  logic                               neg,
    output logic signed [rpfs_pkg::TRIG_W-1:0] sine
);

    localparam int MW   = rpfs_pkg::MAG_W;
    localparam int SQ_W = 2 * MW;
    localparam int FR   = rpfs_pkg::TRIG_FRAC;
    localparam int T_W  = FR - 1;
    localparam int TR_W = T_W + rpfs_pkg::REFINE_W;
    localparam int TW   = rpfs_pkg::TRIG_W;

    logic [MW-1:0]          a_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [MW-1:0]          p_b_reg;
    logic [MW-1:0]          p_b_next;
    logic [SQ_W-1:0]        pp_reg;
    logic [MW-1:0]          p_c_reg;
    logic [T_W-1:0]         t_reg;
    logic [T_W-1:0]         t_next;
    logic [MW-1:0]          p_d_reg;
    logic [TR_W-1:0]        tr_reg;
    logic [MW-1:0]          p_e_reg;
    logic [4:0]             neg_reg;
    logic signed [TW-1:0]   sine_reg;
    logic signed [TW-1:0]   sine_next;

    logic [SQ_W-1:0]        sq_sum;
    logic [SQ_W-1:0]        pp_sum;
    logic [TR_W-1:0]        tr_sum;
    logic [TR_W-1-FR:0]     tr_rnd;

    always_comb
    begin
        sq_sum   = sq_reg + SQ_W'(2 ** (FR - 3));
        p_b_next = MW'({a_reg, 2'b00} - sq_sum[SQ_W-1:FR-2]);

        pp_sum = pp_reg + SQ_W'(2 ** (FR - 1));
        t_next = T_W'({1'b0, p_c_reg} - pp_sum[SQ_W-1:FR]);

        tr_sum = tr_reg + TR_W'(2 ** (FR - 1));
        tr_rnd = tr_sum[TR_W-1:FR];
        if (neg_reg[4])
        begin
            sine_next = TW'(tr_rnd) - TW'(p_e_reg);
        end
        else
        begin
            sine_next = TW'(p_e_reg) - TW'(tr_rnd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= mag;
            sq_reg   <= mag * mag;
            p_b_reg  <= p_b_next;
            pp_reg   <= p_b_reg * p_b_reg;
            p_c_reg  <= p_b_reg;
            t_reg    <= t_next;
            p_d_reg  <= p_c_reg;
            tr_reg   <= t_reg * rpfs_pkg::REFINE_Q30;
            p_e_reg  <= p_d_reg;
            neg_reg  <= {neg_reg[3:0], neg};
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

`default_nettype wire

// ===== design/rotate_point_fast_sincos.sv =====
`default_nettype none

// Rotates a signed Q16.16 point about a pivot by an angle in Q16.16 degrees in a
// y-down frame, using parabolic sine/cosine with the 0.225 refinement and
// saturating the result. Fully pipelined: one point per cycle while no result
// waits untaken. The pipe is the angle reduction (7 stages), the sine units
// (6 stages) and the rotation multiply/sum/saturate (3 stages). The whole pipe
// holds while a result waits untaken; empty slots keep flowing, so point_ready
// is low only while result_valid is high and result_ready is low.

module rotate_point_fast_sincos (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           point_valid,
    output logic           point_ready,
    input  rpfs_pkg::in_t  point,
    output logic           result_valid,
    input  logic           result_ready,
    output rpfs_pkg::out_t result
);

    localparam int NS  = rpfs_pkg::NSTAGE;
    localparam int DW  = rpfs_pkg::DELTA_W;
    localparam int TW  = rpfs_pkg::TRIG_W;
    localparam int MW  = rpfs_pkg::MAG_W;
    localparam int PW  = rpfs_pkg::PROD_W;
    localparam int SW  = rpfs_pkg::SUM_W;
    localparam int RW  = rpfs_pkg::RES_W;
    localparam int FR  = rpfs_pkg::TRIG_FRAC;
    localparam int YW  = rpfs_pkg::Y_W;

    logic                         en;
    logic [NS-1:0]                vld_reg;

    logic [rpfs_pkg::TURN_W:0]    ang_ext;
    logic [rpfs_pkg::TURN_W-1:0]  x_reg;
    logic [rpfs_pkg::TURN_W-1:0]  x_next;
    rpfs_pkg::crd_t               crd_next;
    rpfs_pkg::crd_t               crd_reg [rpfs_pkg::CRD_DEPTH];

    logic [rpfs_pkg::XH_W-1:0]    xh;
    logic [rpfs_pkg::Q45_PROD_W-1:0] q45_prod;
    logic [rpfs_pkg::XH_W-1:0]    xh_reg;
    logic [rpfs_pkg::XL_W-1:0]    xl2_reg;
    logic [rpfs_pkg::Q45_W-1:0]   q45_reg;

    logic [rpfs_pkg::XH_W-1:0]    mh_full;
    logic [rpfs_pkg::MH_W-1:0]    mh_reg;
    logic [rpfs_pkg::XL_W-1:0]    xl3_reg;

    logic [YW-1:0]                y_reg;
    logic [YW-1:0]                y_next;
    logic [rpfs_pkg::BASE_W-1:0]  base_reg;
    logic [rpfs_pkg::BASE_W-1:0]  base_next;

    logic [rpfs_pkg::P5_W-1:0]    prod5;
    logic [rpfs_pkg::QY_W-1:0]    qy_reg;
    logic [rpfs_pkg::BASE_W-1:0]  base5_reg;

    logic [YW-1:0]                up;
    logic signed [YW-1:0]         u_reg;
    logic signed [YW-1:0]         u_next;

    logic signed [YW-1:0]         v_raw;
    logic signed [YW-1:0]         v_wrap;
    logic [YW-1:0]                u_abs;
    logic [YW-1:0]                v_abs;
    logic [MW-1:0]                mag_s_reg;
    logic [MW-1:0]                mag_c_reg;
    logic                         neg_s_reg;
    logic                         neg_c_reg;

    logic signed [TW-1:0]         sin_val;
    logic signed [TW-1:0]         cos_val;

    logic signed [PW-1:0]         cdx_reg;
    logic signed [PW-1:0]         sdy_reg;
    logic signed [PW-1:0]         sdx_reg;
    logic signed [PW-1:0]         cdy_reg;

    logic signed [SW-1:0]         sum_x_reg;
    logic signed [SW-1:0]         sum_y_reg;
    logic signed [SW-1:0]         sum_x_next;
    logic signed [SW-1:0]         sum_y_next;

    logic signed [RW-1:0]         rx_full;
    logic signed [RW-1:0]         ry_full;
    rpfs_pkg::out_t               result_reg;
    rpfs_pkg::out_t               result_next;

    assign en          = !vld_reg[NS-1] || result_ready;
    assign point_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], point_valid};
        end
    end

    always_comb
    begin
        ang_ext = {{2{point.angle_degrees[rpfs_pkg::ANGLE_WIDTH-1]}}, point.angle_degrees};
        x_next  = rpfs_pkg::TURN_W'(rpfs_pkg::TURN_OFFSET - ang_ext);

        crd_next.dx = DW'($signed(point.point_x)) - DW'($signed(point.pivot_x));
        crd_next.dy = DW'($signed(point.pivot_y)) - DW'($signed(point.point_y));
        crd_next.cx = point.pivot_x;
        crd_next.cy = point.pivot_y;

        xh       = x_reg[rpfs_pkg::TURN_W-1:rpfs_pkg::XL_W];
        q45_prod = rpfs_pkg::Q45_PROD_W'(xh) * rpfs_pkg::Q45_PROD_W'(rpfs_pkg::MOD45_RECIP);

        mh_full = xh_reg - rpfs_pkg::XH_W'(q45_reg) * rpfs_pkg::SECTOR_DIV;

        y_next = YW'({xl3_reg, {rpfs_pkg::Y_SHIFT{1'b0}}})
               + YW'(mh_reg) * rpfs_pkg::UQ_STEP_REM
               + rpfs_pkg::ROUND_BIAS;
        base_next = rpfs_pkg::BASE_W'(mh_reg) * rpfs_pkg::UQ_STEP;

        prod5 = rpfs_pkg::P5_W'(y_reg) * rpfs_pkg::P5_W'(rpfs_pkg::DIV45_RECIP);

        up = YW'(base5_reg) + YW'(qy_reg);
        if (up > rpfs_pkg::HALF_TURN)
        begin
            u_next = up - rpfs_pkg::FULL_TURN;
        end
        else
        begin
            u_next = up;
        end

        v_raw = u_reg + rpfs_pkg::QUARTER_TURN;
        if (v_raw > $signed(rpfs_pkg::HALF_TURN))
        begin
            v_wrap = v_raw - rpfs_pkg::FULL_TURN;
        end
        else
        begin
            v_wrap = v_raw;
        end
        u_abs = u_reg[YW-1]  ? -u_reg  : u_reg;
        v_abs = v_wrap[YW-1] ? -v_wrap : v_wrap;

        sum_x_next = SW'(cdx_reg) - SW'(sdy_reg) + SW'(2 ** (FR - 1));
        sum_y_next = -SW'(sdx_reg) - SW'(cdy_reg) + SW'(2 ** (FR - 1));

        rx_full = RW'($signed(sum_x_reg[SW-1:FR])) + RW'(crd_reg[14].cx);
        ry_full = RW'($signed(sum_y_reg[SW-1:FR])) + RW'(crd_reg[14].cy);
        result_next.rotated_x = rpfs_pkg::sat_coord(rx_full);
        result_next.rotated_y = rpfs_pkg::sat_coord(ry_full);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= x_next;
            crd_reg[0] <= crd_next;
            for (int i = 1; i < rpfs_pkg::CRD_DEPTH; i++)
            begin
                crd_reg[i] <= crd_reg[i-1];
            end

            xh_reg  <= xh;
            xl2_reg <= x_reg[rpfs_pkg::XL_W-1:0];
            q45_reg <= q45_prod[rpfs_pkg::Q45_PROD_W-2:rpfs_pkg::XL_W];

            mh_reg  <= mh_full[rpfs_pkg::MH_W-1:0];
            xl3_reg <= xl2_reg;

            y_reg    <= y_next;
            base_reg <= base_next;

            qy_reg    <= prod5[rpfs_pkg::P5_W-1:rpfs_pkg::DIV45_SHIFT];
            base5_reg <= base_reg;

            u_reg <= u_next;

            mag_s_reg <= u_abs[MW-1:0];
            neg_s_reg <= u_reg[YW-1];
            mag_c_reg <= v_abs[MW-1:0];
            neg_c_reg <= v_wrap[YW-1];

            cdx_reg <= cos_val * crd_reg[12].dx;
            sdy_reg <= sin_val * crd_reg[12].dy;
            sdx_reg <= sin_val * crd_reg[12].dx;
            cdy_reg <= cos_val * crd_reg[12].dy;

            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;

            result_reg <= result_next;
        end
    end

    rpfs_sine u_sin (
        .clk  (clk),
        .en   (en),
        .mag  (mag_s_reg),
        .neg  (neg_s_reg),
        .sine (sin_val)
    );

    rpfs_sine u_cos (
        .clk  (clk),
        .en   (en),
        .mag  (mag_c_reg),
        .neg  (neg_c_reg),
        .sine (cos_val)
    );

    assign result_valid = vld_reg[NS-1];
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== design/rpfs_check.sv =====
`default_nettype none

module rpfs_check (
    input logic           clk,
    input logic           rst_n,
    input logic           point_valid,
    input logic           point_ready,
    input logic           result_valid,
    input logic           result_ready,
    input rpfs_pkg::out_t result
);

    a_result_hold : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transfer");

    a_result_stable : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

    a_ready_stall : assert property (@(posedge clk) disable iff (!rst_n)
        point_ready == (!result_valid || result_ready))
        else $error("point_ready does not follow output stall");

    a_idle_accept : assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !result_valid |-> point_ready)
        else $error("point refused while output empty");

endmodule

bind rotate_point_fast_sincos rpfs_check u_rpfs_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
